[rtl/core/tcp_pkg.sv]
`timescale 1ns / 1ps

package tcp_pkg;

   localparam int SCREEN_COLS = 128;
   localparam int SCREEN_ROWS = 64;
   localparam int COL_W       = $clog2(SCREEN_COLS);
   localparam int ROW_W       = $clog2(SCREEN_ROWS);
   localparam int QUO_W       = (COL_W > ROW_W) ? COL_W : ROW_W;

   // numerators reach |x*scale| + (screen/2)*z*2^16, well inside this width
   localparam int NUM_W    = 66;
   localparam int LANE_LAT = 2 + QUO_W;
   localparam int CULL_LAT = 6;
   localparam int CULL_PAD = LANE_LAT - CULL_LAT;

   localparam int CFG_W = 31;
   localparam logic [CFG_W-1:0] NEAR_RESET  = 31'd6554;
   localparam logic [CFG_W-1:0] SCALE_RESET = 31'd7264734;

   // register index, taken from paddr[2]
   localparam logic REG_NEAR  = 1'b0;
   localparam logic REG_SCALE = 1'b1;

   typedef enum logic [1:0] {
      OUT_DRAW = 2'd0,
      OUT_BACK = 2'd1,
      OUT_NEAR = 2'd2,
      OUT_OFF  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic signed [31:0] v0_x;
      logic signed [31:0] v0_y;
      logic signed [31:0] v0_z;
      logic signed [31:0] v1_x;
      logic signed [31:0] v1_y;
      logic signed [31:0] v1_z;
      logic signed [31:0] v2_x;
      logic signed [31:0] v2_y;
      logic signed [31:0] v2_z;
   } req_type;

   typedef struct packed {
      outcome_type outcome;
      logic [6:0]  p0_col;
      logic [5:0]  p0_row;
      logic [6:0]  p1_col;
      logic [5:0]  p1_row;
      logic [6:0]  p2_col;
      logic [5:0]  p2_row;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vertex_type;

   typedef struct packed {
      outcome_type      code;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } lane_result_type;

endpackage

[rtl/core/tcp_cull.sv]
`timescale 1ns / 1ps

module tcp_cull (
   input  logic             clock,
   input  logic             adv,
   input  tcp_pkg::req_type item,
   output logic             back
);
   import tcp_pkg::*;

   logic signed [32:0] ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic signed [32:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   vertex_type         v1_ff, v2_ff, v3_ff;
   logic signed [65:0] p_yz_ff, p_zy_ff, p_zx_ff, p_xz_ff, p_xy_ff, p_yx_ff;
   logic signed [66:0] nx_ff, ny_ff, nz_ff;
   logic signed [64:0] lox_in, loy_in, loz_in, lox_ff, loy_ff, loz_ff;
   logic signed [66:0] hix_in, hiy_in, hiz_in, hix_ff, hiy_ff, hiz_ff;
   logic signed [66:0] slo_ff;
   logic signed [68:0] shi_ff;
   logic signed [100:0] dot_in;
   logic               back_ff;
   logic               pad_ff [CULL_PAD];

   // edge vectors
   always_comb begin
      ax_in = 33'(item.v1_x) - 33'(item.v0_x);
      ay_in = 33'(item.v1_y) - 33'(item.v0_y);
      az_in = 33'(item.v1_z) - 33'(item.v0_z);
      bx_in = 33'(item.v2_x) - 33'(item.v0_x);
      by_in = 33'(item.v2_y) - 33'(item.v0_y);
      bz_in = 33'(item.v2_z) - 33'(item.v0_z);
   end

   // normal split into low 32 unsigned bits and signed high part
   always_comb begin
      lox_in = $signed({1'b0, nx_ff[31:0]}) * v3_ff.x;
      loy_in = $signed({1'b0, ny_ff[31:0]}) * v3_ff.y;
      loz_in = $signed({1'b0, nz_ff[31:0]}) * v3_ff.z;
      hix_in = $signed(nx_ff[66:32]) * v3_ff.x;
      hiy_in = $signed(ny_ff[66:32]) * v3_ff.y;
      hiz_in = $signed(nz_ff[66:32]) * v3_ff.z;
      dot_in = $signed({shi_ff, 32'h0}) + 101'(slo_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         az_ff   <= az_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         bz_ff   <= bz_in;
         v1_ff   <= '{x: item.v0_x, y: item.v0_y, z: item.v0_z};

         p_yz_ff <= ay_ff * bz_ff;
         p_zy_ff <= az_ff * by_ff;
         p_zx_ff <= az_ff * bx_ff;
         p_xz_ff <= ax_ff * bz_ff;
         p_xy_ff <= ax_ff * by_ff;
         p_yx_ff <= ay_ff * bx_ff;
         v2_ff   <= v1_ff;

         nx_ff   <= 67'(p_yz_ff) - 67'(p_zy_ff);
         ny_ff   <= 67'(p_zx_ff) - 67'(p_xz_ff);
         nz_ff   <= 67'(p_xy_ff) - 67'(p_yx_ff);
         v3_ff   <= v2_ff;

         lox_ff  <= lox_in;
         loy_ff  <= loy_in;
         loz_ff  <= loz_in;
         hix_ff  <= hix_in;
         hiy_ff  <= hiy_in;
         hiz_ff  <= hiz_in;

         slo_ff  <= 67'(lox_ff) + 67'(loy_ff) + 67'(loz_ff);
         shi_ff  <= 69'(hix_ff) + 69'(hiy_ff) + 69'(hiz_ff);

         back_ff <= dot_in[100];

         pad_ff[0] <= back_ff;
         for (int i = 1; i < CULL_PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
   end

   assign back = pad_ff[CULL_PAD-1];

endmodule

[rtl/core/tcp_lane.sv]
`timescale 1ns / 1ps

module tcp_lane (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [30:0]              near,
   input  logic [30:0]              scale,
   input  tcp_pkg::vertex_type      vtx,
   output tcp_pkg::lane_result_type res
);
   import tcp_pkg::*;

   localparam logic signed [NUM_W-1:0] HALF_C = NUM_W'(SCREEN_COLS / 2);
   localparam logic signed [NUM_W-1:0] FULL_C = NUM_W'(SCREEN_COLS);
   localparam logic signed [NUM_W-1:0] HALF_R = NUM_W'(SCREEN_ROWS / 2);
   localparam logic signed [NUM_W-1:0] FULL_R = NUM_W'(SCREEN_ROWS);

   logic signed [31:0]      s_sgn;
   logic                    near_in, near1_ff;
   logic signed [63:0]      tx_in, ty_in, tx1_ff, ty1_ff;
   logic signed [31:0]      z1_ff;
   logic signed [NUM_W-1:0] den, numc, numr;
   logic                    col_ok, row_ok;
   outcome_type             code_in;
   logic [NUM_W-1:0]        remc_in, remr_in;

   outcome_type             code_ff [QUO_W+1];
   logic [NUM_W-1:0]        den_ff  [QUO_W+1];
   logic [NUM_W-1:0]        remc_ff [QUO_W+1];
   logic [NUM_W-1:0]        remr_ff [QUO_W+1];
   logic [QUO_W-1:0]        qc_ff   [QUO_W+1];
   logic [QUO_W-1:0]        qr_ff   [QUO_W+1];

   always_comb begin
      s_sgn   = $signed({1'b0, scale});
      near_in = (vtx.z < $signed({1'b0, near})) || (vtx.z == 32'sd0);
      tx_in   = vtx.x * s_sgn;
      ty_in   = vtx.y * s_sgn;
   end

   // den = z in Q16.16 scaled by 2^16; on screen iff -den < num < full*den
   always_comb begin
      den     = $signed({{(NUM_W-48){z1_ff[31]}}, z1_ff, 16'h0});
      numc    = den * HALF_C + NUM_W'(tx1_ff);
      numr    = den * HALF_R - NUM_W'(ty1_ff);
      col_ok  = (numc + den > 0) && (numc < den * FULL_C);
      row_ok  = (numr + den > 0) && (numr < den * FULL_R);
      if (near1_ff) begin
         code_in = OUT_NEAR;
      end else if (col_ok && row_ok) begin
         code_in = OUT_DRAW;
      end else begin
         code_in = OUT_OFF;
      end
      // a sum in (-1, 0) truncates to zero
      remc_in = numc[NUM_W-1] ? '0 : numc;
      remr_in = numr[NUM_W-1] ? '0 : numr;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         near1_ff   <= near_in;
         tx1_ff     <= tx_in;
         ty1_ff     <= ty_in;
         z1_ff      <= vtx.z;
         code_ff[0] <= code_in;
         den_ff[0]  <= den;
         remc_ff[0] <= remc_in;
         remr_ff[0] <= remr_in;
         qc_ff[0]   <= '0;
         qr_ff[0]   <= '0;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar i = 1; i <= QUO_W; i++) begin : g_div
      logic [NUM_W-1:0] dsh;
      logic             c_ge, r_ge;
      assign dsh  = den_ff[i-1] << (QUO_W - i);
      assign c_ge = remc_ff[i-1] >= dsh;
      assign r_ge = remr_ff[i-1] >= dsh;
      always_ff @(posedge clock) begin
         if (adv) begin
            code_ff[i] <= code_ff[i-1];
            den_ff[i]  <= den_ff[i-1];
            remc_ff[i] <= c_ge ? remc_ff[i-1] - dsh : remc_ff[i-1];
            remr_ff[i] <= r_ge ? remr_ff[i-1] - dsh : remr_ff[i-1];
            qc_ff[i]   <= {qc_ff[i-1][QUO_W-2:0], c_ge};
            qr_ff[i]   <= {qr_ff[i-1][QUO_W-2:0], r_ge};
         end
      end
   end

   always_comb begin
      res.code = code_ff[QUO_W];
      res.col  = qc_ff[QUO_W][COL_W-1:0];
      res.row  = qr_ff[QUO_W][ROW_W-1:0];
   end

endmodule

[rtl/core/tcp_merge.sv]
`timescale 1ns / 1ps

module tcp_merge (
   input  logic                     back,
   input  tcp_pkg::lane_result_type res [3],
   output tcp_pkg::rsp_type         rsp
);
   import tcp_pkg::*;

   // first failure wins: cull, then vertices in order
   always_comb begin
      rsp = '0;
      if (back) begin
         rsp.outcome = OUT_BACK;
      end else if (res[0].code != OUT_DRAW) begin
         rsp.outcome = res[0].code;
      end else if (res[1].code != OUT_DRAW) begin
         rsp.outcome = res[1].code;
      end else if (res[2].code != OUT_DRAW) begin
         rsp.outcome = res[2].code;
      end else begin
         rsp.outcome = OUT_DRAW;
         rsp.p0_col  = res[0].col;
         rsp.p0_row  = res[0].row;
         rsp.p1_col  = res[1].col;
         rsp.p1_row  = res[1].row;
         rsp.p2_col  = res[2].col;
         rsp.p2_row  = res[2].row;
      end
   end

endmodule

[rtl/core/triangle_cull_and_project_core.sv]
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_data  (three camera-space vertices)
// rsp       out        rsp_valid/rsp_ready  rsp_data  (outcome and screen coordinates)
// csr       in/out     psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// one triangle per cycle while rsp is not stalled; a result passes the scale products,
// the bounds check, the 7-stage restoring divider in each vertex lane and the rsp register
// the whole pipeline holds while a finished result waits at rsp
// synchronous reset clears the valid pipeline and loads the register defaults

module triangle_cull_and_project_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcp_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tcp_pkg::*;

   logic [CFG_W-1:0] near_ff, scale_ff;
   logic             vld_ff [LANE_LAT];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             adv;
   logic             back;
   vertex_type       vtx [3];
   lane_result_type  res [3];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = {1'b0, (paddr[2] == REG_SCALE) ? scale_ff : near_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= NEAR_RESET;
         scale_ff <= SCALE_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_NEAR:  near_ff  <= pwdata[CFG_W-1:0];
            REG_SCALE: scale_ff <= pwdata[CFG_W-1:0];
            default:   ;
         endcase
      end
   end

   assign vtx[0] = '{x: req_data.v0_x, y: req_data.v0_y, z: req_data.v0_z};
   assign vtx[1] = '{x: req_data.v1_x, y: req_data.v1_y, z: req_data.v1_z};
   assign vtx[2] = '{x: req_data.v2_x, y: req_data.v2_y, z: req_data.v2_z};

   tcp_cull u_cull (
      .clock (clock),
      .adv   (adv),
      .item  (req_data),
      .back  (back)
   );

   for (genvar l = 0; l < 3; l++) begin : g_lane
      tcp_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .near  (near_ff),
         .scale (scale_ff),
         .vtx   (vtx[l]),
         .res   (res[l])
      );
   end

   tcp_merge u_merge (
      .back (back),
      .res  (res),
      .rsp  (rsp_in)
   );

   // beat tracking alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LANE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[dv/triangle_cull_and_project_core_tb.sv]
`timescale 1ns / 1ps

module triangle_cull_and_project_core_tb;
   import tcp_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 20;
   localparam int PHASE_ITEMS = 157;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [CFG_W-1:0] near_cfg;
   logic [CFG_W-1:0] scale_cfg;
   rsp_type          pending_rsp[$];
   int               sender_idle;
   int               receiver_idle;
   int               mismatches;
   int               stall_cycles;
   stim_row_type     directed[$];

   triangle_cull_and_project_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic rsp_type project_triangle(req_type t);
      longint              vx[3], vy[3], vz[3];
      logic signed [127:0] ax, ay, az, bx, by, bz, nx, ny, nz, dot;
      longint              den, num, c, r, s;
      rsp_type             res;
      vx[0] = t.v0_x; vy[0] = t.v0_y; vz[0] = t.v0_z;
      vx[1] = t.v1_x; vy[1] = t.v1_y; vz[1] = t.v1_z;
      vx[2] = t.v2_x; vy[2] = t.v2_y; vz[2] = t.v2_z;
      res = '0;
      res.outcome = OUT_DRAW;
      ax = vx[1] - vx[0]; ay = vy[1] - vy[0]; az = vz[1] - vz[0];
      bx = vx[2] - vx[0]; by = vy[2] - vy[0]; bz = vz[2] - vz[0];
      nx = ay * bz - az * by;
      ny = az * bx - ax * bz;
      nz = ax * by - ay * bx;
      dot = nx * 128'(signed'(vx[0])) + ny * 128'(signed'(vy[0]))
            + nz * 128'(signed'(vz[0]));
      if (dot < 0) begin
         res.outcome = OUT_BACK;
         return res;
      end
      s = longint'({33'd0, scale_cfg});
      for (int i = 0; i < 3; i++) begin
         if (vz[i] < longint'({33'd0, near_cfg}) || vz[i] == 0) begin
            res = '0;
            res.outcome = OUT_NEAR;
            return res;
         end
         den = vz[i] * 65536;
         num = longint'(SCREEN_COLS / 2) * den + vx[i] * s;
         c = num / den;
         num = longint'(SCREEN_ROWS / 2) * den - vy[i] * s;
         r = num / den;
         if (c < 0 || c >= SCREEN_COLS || r < 0 || r >= SCREEN_ROWS) begin
            res = '0;
            res.outcome = OUT_OFF;
            return res;
         end
         case (i)
            0: begin res.p0_col = c[6:0]; res.p0_row = r[5:0]; end
            1: begin res.p1_col = c[6:0]; res.p1_row = r[5:0]; end
            default: begin res.p2_col = c[6:0]; res.p2_row = r[5:0]; end
         endcase
      end
      return res;
   endfunction

   function automatic req_type make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x2, int y2, int z2);
      req_type t;
      t.v0_x = x0; t.v0_y = y0; t.v0_z = z0;
      t.v1_x = x1; t.v1_y = y1; t.v1_z = z1;
      t.v2_x = x2; t.v2_y = y2; t.v2_z = z2;
      return t;
   endfunction

   function automatic rsp_type make_rsp(outcome_type o, int c0, int r0, int c1, int r1,
                                        int c2, int r2);
      rsp_type r;
      r.outcome = o;
      r.p0_col = 7'(c0); r.p0_row = 6'(r0);
      r.p1_col = 7'(c1); r.p1_row = 6'(r1);
      r.p2_col = 7'(c2); r.p2_row = 6'(r2);
      return r;
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // vertex aimed near the screen, sometimes a little past an edge
   function automatic void aim_vertex(output int x, output int y, output int z);
      longint zl, cx, cy, s;
      s = (scale_cfg == 0) ? 1 : longint'({33'd0, scale_cfg});
      zl = longint'({33'd0, near_cfg}) + $urandom_range(40 * 65536);
      if ($urandom_range(19) == 0) zl = longint'({33'd0, near_cfg}) - $urandom_range(3);
      if (zl > 64'sd2147483647) zl = 64'sd2147483647;
      cx = longint'($urandom_range(140)) - 70;
      cy = longint'($urandom_range(76)) - 38;
      z = clamp32(zl);
      x = clamp32((cx * zl * 65536) / s + longint'($urandom_range(2000)) - 1000);
      y = clamp32((cy * zl * 65536) / s + longint'($urandom_range(2000)) - 1000);
   endfunction

   function automatic req_type random_tri();
      req_type t;
      int      x, y, z;
      if ($urandom_range(99) < 25) begin
         t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
         return t;
      end
      aim_vertex(x, y, z); t.v0_x = x; t.v0_y = y; t.v0_z = z;
      aim_vertex(x, y, z); t.v1_x = x; t.v1_y = y; t.v1_z = z;
      aim_vertex(x, y, z); t.v2_x = x; t.v2_y = y; t.v2_z = z;
      if ($urandom_range(19) == 0) t.v1_z = 0;
      return t;
   endfunction

   task automatic send_tri(req_type t, bit typed, rsp_type want);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(typed ? want : project_triangle(t));
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_NEAR) near_cfg = value[CFG_W-1:0];
      else scale_cfg = value[CFG_W-1:0];
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.outcome !== want.outcome || rsp_data.p0_col !== want.p0_col ||
                rsp_data.p0_row !== want.p0_row || rsp_data.p1_col !== want.p1_col ||
                rsp_data.p1_row !== want.p1_row || rsp_data.p2_col !== want.p2_col ||
                rsp_data.p2_row !== want.p2_row) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      mismatches    = 0;
      stall_cycles  = 0;
      near_cfg      = NEAR_RESET;
      scale_cfg     = SCALE_RESET;
      sender_idle   = 20;
      receiver_idle = 86;

      // degenerate, simple and extreme cases; the typed ones are easy to read off by hand
      directed.push_back('{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                           make_rsp(OUT_NEAR, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{make_tri(0, 0, 65536, 0, 0, 65536, 0, 0, 65536), 1,
                           make_rsp(OUT_DRAW, 64, 32, 64, 32, 64, 32)});
      directed.push_back('{make_tri(0, 0, 65536, 0, 65536, 65536, 65536, 0, 65536), 1,
                           make_rsp(OUT_BACK, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{make_tri(0, 0, 65536, 65536, 0, 65536, 0, 65536, 65536), 0, none});
      directed.push_back('{make_tri(0, 0, -65536, 0, 0, -65536, 0, 0, -65536), 1,
                           make_rsp(OUT_NEAR, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{make_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, none});
      directed.push_back('{make_tri(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h80000000), 1,
                           make_rsp(OUT_NEAR, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{make_tri(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000), 0, none});
      directed.push_back('{make_tri(32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                                    32'h80000000, 32'h7FFFFFFF, 32'h00010000,
                                    0, 0, 32'h7FFFFFFF), 0, none});
      // sum just below zero truncates to column 0
      directed.push_back('{make_tri(-38132, 0, 65536, -38132, 0, 65536,
                                    -38132, 0, 65536), 0, none});
      directed.push_back('{make_tri(0, 0, 6554, 0, 0, 6553, 0, 0, 6554), 1,
                           make_rsp(OUT_NEAR, 0, 0, 0, 0, 0, 0)});
      directed.push_back('{make_tri(0, 0, 65536, 0, 0, 65536, 600000, 0, 65536), 0, none});
      directed.push_back('{make_tri(0, 0, 65536, 0, -300000, 65536, 0, 0, 65536), 0, none});
      directed.push_back('{make_tri(-1, 1, 1, 1, -1, 1, 1, 1, 1), 0, none});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_tri(directed[i].item, directed[i].typed, directed[i].want);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(REG_NEAR, 32'd6554); write_reg(REG_SCALE, 32'd7264734); end
            1: begin write_reg(REG_NEAR, 32'h80000000); write_reg(REG_SCALE, 32'hFFFFFFFF); end
            2: begin write_reg(REG_NEAR, 32'h7FFFFFFF); write_reg(REG_SCALE, 32'd1); end
            3: begin write_reg(REG_NEAR, 32'd65536); write_reg(REG_SCALE, 32'd7264734); end
            default: begin
               write_reg(REG_NEAR, $urandom_range(200000));
               write_reg(REG_SCALE, $urandom_range(1, 40000000) | ($urandom & 32'h80000000));
            end
         endcase
         sender_idle   = (phase < 2) ? 20 : (phase < 4) ? 86 : 0;
         receiver_idle = (phase < 2) ? 86 : (phase < 4) ? 20 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) send_tri(random_tri(), 0, none);
         wait_drained();
      end

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
